// ===== rtl/hsup_pkg.sv =====
`default_nettype none

package hsup_pkg;

  localparam int TEMP_W     = 8;
  localparam int TARGET_W   = 7;
  localparam int KEY_W      = 4;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_STANDBY = 2'd0,
    MODE_OPER    = 2'd1,
    MODE_NORMAL  = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_KEY    = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_IDLE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DRIVE_OFF       = 2'd0,
    DRIVE_GAIN      = 2'd1,
    DRIVE_ZERO_GAIN = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    ENTRY_NONE = 2'd0,
    ENTRY_ONE  = 2'd1,
    ENTRY_TWO  = 2'd2
  } entry_t;

  localparam logic [CFG_IDX_W-1:0] CFG_BAND      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [KEY_W-1:0] KEY_START_STOP = 4'd12;
  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX  = 4'd9;

  localparam logic [TEMP_W-1:0]   BAND_RST      = 8'd5;
  localparam logic [TEMP_W-1:0]   OVERSHOOT_RST = 8'd10;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RST   = 16'd1800;
  localparam logic [TARGET_W-1:0] TARGET_RST    = 7'd25;
  localparam logic [TEMP_W-1:0]   MEASURED_RST  = 8'd25;
  localparam logic [TARGET_W-1:0] TARGET_MAX    = 7'd99;

  typedef struct packed {
    logic [TEMP_W-1:0]  band;
    logic [TEMP_W-1:0]  overshoot;
    logic [COUNT_W-1:0] timeout;
  } hsup_cfg_t;

  typedef struct packed {
    mode_t               mode;
    entry_t              entry;
    logic [TARGET_W-1:0] target;
    logic [TEMP_W-1:0]   measured;
    logic [COUNT_W-1:0]  under_count;
    logic                timeout_flag;
  } hsup_state_t;

endpackage

`default_nettype wire

// ===== rtl/hsup_if.sv =====
`default_nettype none

interface hsup_req_if;
  import hsup_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key_code;
  logic [TEMP_W-1:0]   temp_sample;

  modport source (output valid, cmd, key_code, temp_sample, input ready);
  modport sink (input valid, cmd, key_code, temp_sample, output ready);
endinterface

interface hsup_res_if;
  import hsup_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [1:0]          drive_mode;
  logic [TARGET_W-1:0] target_temp;
  logic [TEMP_W-1:0]   measured_temp;
  logic                timeout_hit;

  modport source (output valid, mode, drive_mode, target_temp, measured_temp, timeout_hit,
                  input ready);
  modport sink (input valid, mode, drive_mode, target_temp, measured_temp, timeout_hit,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/hsup_cfg.sv =====
`default_nettype none

module hsup_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wen,
  input  logic [hsup_pkg::CFG_IDX_W-1:0]    idx,
  input  logic [hsup_pkg::CFG_DATA_W-1:0]   data,
  output hsup_pkg::hsup_cfg_t               cfg
);
  import hsup_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.band      <= BAND_RST;
      cfg.overshoot <= OVERSHOOT_RST;
      cfg.timeout   <= TIMEOUT_RST;
    end else if (wen) begin
      case (idx)
        CFG_BAND:      cfg.band      <= data[TEMP_W-1:0];
        CFG_OVERSHOOT: cfg.overshoot <= data[TEMP_W-1:0];
        CFG_TIMEOUT:   cfg.timeout   <= data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hsup_eval.sv =====
`default_nettype none

module hsup_eval (
  input  hsup_pkg::hsup_state_t             cur,
  input  hsup_pkg::cmd_t                    cmd,
  input  logic [hsup_pkg::KEY_W-1:0]        key,
  input  logic [hsup_pkg::TEMP_W-1:0]       sample,
  input  hsup_pkg::hsup_cfg_t               cfg,
  output hsup_pkg::hsup_state_t             nxt,
  output hsup_pkg::drive_t                  drive
);
  import hsup_pkg::*;

  typedef struct packed {
    logic in_band;
    logic under;
    logic over;
  } band_t;

  function automatic band_t check_band(logic [TEMP_W-1:0] meas, logic [TARGET_W-1:0] tgt,
                                       hsup_cfg_t c);
    logic [TEMP_W-1:0] tgt_ext;
    logic [TEMP_W-1:0] diff;
    band_t             r;
    tgt_ext   = {{(TEMP_W-TARGET_W){1'b0}}, tgt};
    diff      = (meas >= tgt_ext) ? meas - tgt_ext : tgt_ext - meas;
    r.in_band = diff <= c.band;
    r.under   = (tgt_ext > meas) && (diff > c.band);
    r.over    = (meas > tgt_ext) && (diff > c.overshoot);
    return r;
  endfunction

  hsup_state_t applied;
  logic        stopped;
  band_t       cur_chk;
  band_t       app_chk;

  assign cur_chk = check_band(cur.measured, cur.target, cfg);
  assign app_chk = check_band(applied.measured, applied.target, cfg);

  // apply the request itself
  always_comb begin
    logic [TARGET_W+3:0] entry_sum;
    entry_sum = ({4'b0, cur.target} << 3) + ({4'b0, cur.target} << 1)
              + {{TARGET_W{1'b0}}, key};
    applied = cur;
    stopped = 1'b0;
    if (cur.mode != MODE_ERROR) begin
      case (cmd)
        CMD_TICK: begin
          if (cur.mode == MODE_OPER || cur.mode == MODE_NORMAL) begin
            if (cur_chk.under) begin
              if (cur.under_count < cfg.timeout) begin
                applied.under_count = cur.under_count + 1'b1;
              end
            end else begin
              applied.under_count = '0;
            end
            if (applied.under_count >= cfg.timeout) begin
              applied.timeout_flag = 1'b1;
            end
          end
        end
        CMD_KEY: begin
          if (cur.mode == MODE_STANDBY) begin
            if (key == KEY_START_STOP) begin
              applied.mode  = MODE_OPER;
              applied.entry = ENTRY_NONE;
            end else if (key <= KEY_DIGIT_MAX) begin
              case (cur.entry)
                ENTRY_NONE: begin
                  applied.target = {{(TARGET_W-KEY_W){1'b0}}, key};
                  applied.entry  = ENTRY_ONE;
                end
                ENTRY_ONE: begin
                  applied.target = entry_sum[TARGET_W-1:0];
                  applied.entry  = ENTRY_TWO;
                end
                default: ;
              endcase
            end
          end else if (key == KEY_START_STOP) begin
            // stop wins over the band checks
            applied.mode  = MODE_STANDBY;
            applied.entry = ENTRY_NONE;
            stopped       = 1'b1;
          end
        end
        CMD_SAMPLE: applied.measured = sample;
        default: ;
      endcase
    end
  end

  // settle operational / normal / error against the band, overshoot and timeout
  always_comb begin
    nxt = applied;
    if (!stopped && (applied.mode == MODE_OPER || applied.mode == MODE_NORMAL)) begin
      if (app_chk.over || (app_chk.under && applied.timeout_flag)) begin
        nxt.mode = MODE_ERROR;
      end else if (app_chk.in_band) begin
        nxt.mode = MODE_NORMAL;
      end else begin
        nxt.mode = MODE_OPER;
      end
    end
  end

  always_comb begin
    case (nxt.mode)
      MODE_OPER:   drive = DRIVE_GAIN;
      MODE_NORMAL: drive = DRIVE_ZERO_GAIN;
      default:     drive = DRIVE_OFF;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/heater_supervisor_fsm.sv =====
// Heater supervisor. Each request is a timer tick, a key press, a temperature
// sample or an idle; each produces exactly one result showing mode, drive,
// target, latest sample and the sticky undershoot timeout flag after that
// request. The mode update is a single combinational pass from the state
// register into the state and result registers, so a new request is taken
// every clock while the result register is empty or being drained. Error mode
// is latched until reset. Configuration (band tolerance, overshoot limit,
// timeout ticks) is written through the plain write port while no request is
// in flight, a rule on the user that the block does not enforce; an index beyond the list is ignored.
`default_nettype none

module heater_supervisor_fsm (
  input  logic                              clk,
  input  logic                              rst,
  hsup_req_if.sink                          req_ch,
  hsup_res_if.source                        res_ch,
  input  logic                              cfg_wen,
  input  logic [hsup_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hsup_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import hsup_pkg::*;

  hsup_cfg_t   cfg;
  hsup_state_t st;
  hsup_state_t st_next;
  drive_t      drive;
  logic        accept;

  logic                res_valid;
  mode_t               res_mode;
  drive_t              res_drive;
  logic [TARGET_W-1:0] res_target;
  logic [TEMP_W-1:0]   res_measured;
  logic                res_timeout;

  hsup_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wen  (cfg_wen),
    .idx  (cfg_idx),
    .data (cfg_data),
    .cfg  (cfg)
  );

  hsup_eval u_eval (
    .cur    (st),
    .cmd    (cmd_t'(req_ch.cmd)),
    .key    (req_ch.key_code),
    .sample (req_ch.temp_sample),
    .cfg    (cfg),
    .nxt    (st_next),
    .drive  (drive)
  );

  assign req_ch.ready = !res_valid || res_ch.ready;
  assign accept       = req_ch.valid && req_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= MODE_STANDBY;
      st.entry        <= ENTRY_NONE;
      st.target       <= TARGET_RST;
      st.measured     <= MEASURED_RST;
      st.under_count  <= '0;
      st.timeout_flag <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (accept) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (res_ch.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_mode     <= st_next.mode;
      res_drive    <= drive;
      res_target   <= st_next.target;
      res_measured <= st_next.measured;
      res_timeout  <= st_next.timeout_flag;
    end
  end

  assign res_ch.valid         = res_valid;
  assign res_ch.mode          = res_mode;
  assign res_ch.drive_mode    = res_drive;
  assign res_ch.target_temp   = res_target;
  assign res_ch.measured_temp = res_measured;
  assign res_ch.timeout_hit   = res_timeout;

  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    st.mode == MODE_ERROR |=> st.mode == MODE_ERROR)
    else $error("error mode left without reset");

  a_timeout_sticky: assert property (@(posedge clk) disable iff (rst)
    st.timeout_flag |=> st.timeout_flag)
    else $error("timeout flag cleared without reset");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid && res_mode == st.mode && res_target == st.target)
    else $error("result does not match updated state");

  a_target_range: assert property (@(posedge clk) disable iff (rst)
    st.target <= TARGET_MAX)
    else $error("target out of range");

  a_entry_standby: assert property (@(posedge clk) disable iff (rst)
    st.entry != ENTRY_NONE |-> st.mode == MODE_STANDBY)
    else $error("digit entry active outside standby");

endmodule

`default_nettype wire

// ===== test/heater_supervisor_check.sv =====
module heater_supervisor_check (
  input  logic                            clk,
  input  logic                            rst,
  hsup_req_if                             req_ch,
  hsup_res_if                             res_ch,
  input  logic                            cfg_wen,
  input  logic [hsup_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [hsup_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fails,
  output int                              pending,
  output int                              checked
);
  import hsup_pkg::*;

  typedef struct packed {
    mode_t               mode;
    drive_t              drive;
    logic [TARGET_W-1:0] target;
    logic [TEMP_W-1:0]   measured;
    logic                flag;
  } heater_view_t;

  hsup_state_t  sup;
  hsup_cfg_t    limits;
  heater_view_t awaited_views[$];
  int           fail_total = 0;
  int           checked_total = 0;

  // applies one request to the supervisor copy and returns what the block should show
  function heater_view_t supervise(input cmd_t c, input logic [KEY_W-1:0] k,
                                   input logic [TEMP_W-1:0] t);
    heater_view_t view;
    int           diff;
    bit           stopped;
    stopped = 1'b0;
    if (sup.mode != MODE_ERROR) begin
      case (c)
        CMD_TICK: begin
          if (sup.mode == MODE_OPER || sup.mode == MODE_NORMAL) begin
            if (int'(sup.target) - int'(sup.measured) > int'(limits.band)) begin
              if (sup.under_count < limits.timeout)
                sup.under_count = sup.under_count + 1'b1;
            end else begin
              sup.under_count = '0;
            end
            if (sup.under_count >= limits.timeout)
              sup.timeout_flag = 1'b1;
          end
        end
        CMD_KEY: begin
          if (sup.mode == MODE_STANDBY) begin
            if (k == KEY_START_STOP) begin
              sup.mode  = MODE_OPER;
              sup.entry = ENTRY_NONE;
            end else if (k <= KEY_DIGIT_MAX) begin
              case (sup.entry)
                ENTRY_NONE: begin
                  sup.target = 7'(k);
                  sup.entry  = ENTRY_ONE;
                end
                ENTRY_ONE: begin
                  sup.target = sup.target * 7'd10 + 7'(k);
                  sup.entry  = ENTRY_TWO;
                end
                default: ;
              endcase
            end
          end else if (k == KEY_START_STOP) begin
            // stop wins over the band checks
            sup.mode  = MODE_STANDBY;
            sup.entry = ENTRY_NONE;
            stopped   = 1'b1;
          end
        end
        CMD_SAMPLE: sup.measured = t;
        default: ;
      endcase
      if (!stopped && (sup.mode == MODE_OPER || sup.mode == MODE_NORMAL)) begin
        diff     = int'(sup.measured) - int'(sup.target);
        sup.mode = (diff <= int'(limits.band) && -diff <= int'(limits.band)) ?
                   MODE_NORMAL : MODE_OPER;
        if (diff > int'(limits.overshoot) ||
            (-diff > int'(limits.band) && sup.timeout_flag))
          sup.mode = MODE_ERROR;
      end
    end
    view.mode     = sup.mode;
    view.drive    = (sup.mode == MODE_OPER) ? DRIVE_GAIN :
                    (sup.mode == MODE_NORMAL) ? DRIVE_ZERO_GAIN : DRIVE_OFF;
    view.target   = sup.target;
    view.measured = sup.measured;
    view.flag     = sup.timeout_flag;
    return view;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    heater_view_t want;
    if (rst) begin
      sup    = '{mode: MODE_STANDBY, entry: ENTRY_NONE, target: TARGET_RST,
                 measured: MEASURED_RST, under_count: '0, timeout_flag: 1'b0};
      limits = '{band: BAND_RST, overshoot: OVERSHOOT_RST, timeout: TIMEOUT_RST};
      awaited_views.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_idx)
          CFG_BAND:      limits.band      = cfg_data[TEMP_W-1:0];
          CFG_OVERSHOOT: limits.overshoot = cfg_data[TEMP_W-1:0];
          CFG_TIMEOUT:   limits.timeout   = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // a result leaving now belongs to an earlier request, so pop before push
      if (res_ch.valid && res_ch.ready) begin
        if (awaited_views.size() == 0) begin
          $error("result with no request waiting: mode %0d target %0d measured %0d",
                 res_ch.mode, res_ch.target_temp, res_ch.measured_temp);
          fail_total++;
        end else begin
          want = awaited_views.pop_front();
          checked_total++;
          compare_field("mode", want.mode, res_ch.mode);
          compare_field("drive_mode", want.drive, res_ch.drive_mode);
          compare_field("target_temp", want.target, res_ch.target_temp);
          compare_field("measured_temp", want.measured, res_ch.measured_temp);
          compare_field("timeout_hit", want.flag, res_ch.timeout_hit);
        end
      end
      if (req_ch.valid && req_ch.ready)
        awaited_views.push_back(supervise(cmd_t'(req_ch.cmd), req_ch.key_code,
                                          req_ch.temp_sample));
    end
    fails   <= fail_total;
    pending <= awaited_views.size();
    checked <= checked_total;
  end

endmodule

// ===== test/heater_supervisor_fsm_test.sv =====
module heater_supervisor_fsm_test;
  import hsup_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails, pending, checked;
  int                    cycles = 0;

  hsup_req_if req_ch();
  hsup_res_if res_ch();

  heater_supervisor_fsm DUT (
    .clk      (clk),
    .rst      (rst),
    .req_ch   (req_ch),
    .res_ch   (res_ch),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  heater_supervisor_check checker_i (
    .clk      (clk),
    .rst      (rst),
    .req_ch   (req_ch),
    .res_ch   (res_ch),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending),
    .checked  (checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus-side view of the supervisor, just enough to keep samples below overshoot
  int     tgt = 25;
  entry_t digits_in = ENTRY_NONE;
  bit     running = 1'b0;
  int     band_cur = 5;
  int     over_cur = 10;
  bit     gaps_on = 1'b1;
  bit     stall_on = 1'b1;
  bit     hold_ask = 1'b0;
  int     sent = 0;
  int     counted = 0;
  int     reg_sets = 0;

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = 240;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_on) begin
        res_ch.ready <= ($urandom_range(0, 99) >= 27);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send(input cmd_t c, input logic [KEY_W-1:0] k, input logic [TEMP_W-1:0] t);
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.key_code    <= k;
    req_ch.temp_sample <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    if (!(c == CMD_IDLE || (c == CMD_KEY && k > KEY_DIGIT_MAX && k != KEY_START_STOP)))
      counted++;
    if (c == CMD_KEY) begin
      if (!running) begin
        if (k == KEY_START_STOP) begin
          running   = 1'b1;
          digits_in = ENTRY_NONE;
        end else if (k <= KEY_DIGIT_MAX) begin
          if (digits_in == ENTRY_NONE) begin
            tgt       = k;
            digits_in = ENTRY_ONE;
          end else if (digits_in == ENTRY_ONE) begin
            tgt       = tgt * 10 + k;
            digits_in = ENTRY_TWO;
          end
        end
      end else if (k == KEY_START_STOP) begin
        running   = 1'b0;
        digits_in = ENTRY_NONE;
      end
    end
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 27) begin
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= 2'($urandom);
        req_ch.key_code    <= 4'($urandom);
        req_ch.temp_sample <= 8'($urandom);
        @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input int b, input int o, input int tmo);
    cfg_wen  <= 1'b1;
    cfg_idx  <= CFG_BAND;
    cfg_data <= {8'($urandom), 8'(b)};
    @(posedge clk);
    cfg_idx  <= CFG_OVERSHOOT;
    cfg_data <= {8'($urandom), 8'(o)};
    @(posedge clk);
    cfg_idx  <= CFG_TIMEOUT;
    cfg_data <= 16'(tmo);
    @(posedge clk);
    cfg_idx  <= CFG_UNUSED;
    cfg_data <= 16'($urandom);
    @(posedge clk);
    cfg_wen  <= 1'b0;
    @(posedge clk);
    band_cur = b;
    over_cur = o;
    reg_sets++;
  endtask

  // sample near the band and overshoot edges; bounded keeps it from overshooting
  function automatic logic [TEMP_W-1:0] pick_temp(input bit bounded);
    int t, hi;
    hi = bounded ? tgt + over_cur : 255;
    if (hi > 255) hi = 255;
    case ($urandom_range(0, 7))
      0: t = $urandom_range(0, 255);
      1: t = tgt;
      2: t = tgt + band_cur;
      3: t = tgt + band_cur + 1;
      4: t = tgt - band_cur;
      5: t = tgt - band_cur - 1;
      6: t = tgt + over_cur + (bounded ? 0 : 1);
      default: t = tgt - band_cur + int'($urandom_range(0, 2 * band_cur));
    endcase
    if (t < 0) t = 0;
    if (t > hi) t = hi;
    return 8'(t);
  endfunction

  task automatic send_noise();
    int k;
    case ($urandom_range(0, 2))
      0: send(CMD_IDLE, 4'($urandom), 8'($urandom));
      1: begin
        k = $urandom_range(10, 14);
        if (k >= KEY_START_STOP) k++;
        send(CMD_KEY, 4'(k), 8'($urandom));
      end
      default: send(CMD_TICK, 4'($urandom), 8'($urandom));
    endcase
  endtask

  // target entry, a sample, start, a random run, stop
  task automatic run_session(input bit bounded);
    int r;
    repeat ($urandom_range(0, 2)) send_noise();
    repeat ($urandom_range(0, 3)) send(CMD_KEY, 4'($urandom_range(0, 9)), 8'($urandom));
    if ($urandom_range(0, 3) == 0) send(CMD_SAMPLE, 4'($urandom), 8'($urandom));
    send(CMD_SAMPLE, 4'($urandom), pick_temp(bounded));
    send(CMD_KEY, KEY_START_STOP, 8'($urandom));
    repeat ($urandom_range(4, 40)) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send(CMD_TICK, 4'($urandom), 8'($urandom));
      end else if (r < 82) begin
        send(CMD_SAMPLE, 4'($urandom), pick_temp(bounded));
      end else if (r < 88) begin
        send(CMD_KEY, 4'($urandom_range(0, 9)), 8'($urandom));
      end else if (r < 91) begin
        send(CMD_KEY, KEY_START_STOP, 8'($urandom));
        send(CMD_KEY, KEY_START_STOP, 8'($urandom));
      end else begin
        send_noise();
      end
    end
    send(CMD_KEY, KEY_START_STOP, 8'($urandom));
  endtask

  task automatic run_phase(input int goal);
    int first;
    first = counted;
    while (counted - first < goal) run_session(1'b1);
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_IDLE;
    req_ch.key_code    <= '0;
    req_ch.temp_sample <= '0;
    cfg_wen            <= 1'b0;
    cfg_idx            <= CFG_BAND;
    cfg_data           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, standby corners, digit entry, band edges
    send(CMD_IDLE, 4'd15, 8'd255);
    send(CMD_TICK, 4'd0, 8'd0);
    send(CMD_KEY, 4'd10, 8'd1);
    send(CMD_KEY, 4'd11, 8'd2);
    send(CMD_KEY, 4'd13, 8'd4);
    send(CMD_KEY, 4'd14, 8'd8);
    send(CMD_KEY, 4'd15, 8'd16);
    send(CMD_SAMPLE, 4'd0, 8'd255);
    send(CMD_SAMPLE, 4'd15, 8'd0);
    send(CMD_KEY, 4'd9, 8'd0);
    send(CMD_KEY, 4'd9, 8'd0);
    send(CMD_KEY, 4'd5, 8'd0);   // third digit is dropped
    send(CMD_SAMPLE, 4'd0, 8'd99);
    send(CMD_KEY, KEY_START_STOP, 8'd0);
    send(CMD_KEY, 4'd3, 8'd0);
    send(CMD_SAMPLE, 4'd0, 8'd109);   // right at the overshoot limit
    send(CMD_SAMPLE, 4'd0, 8'd94);
    send(CMD_SAMPLE, 4'd0, 8'd93);
    send(CMD_TICK, 4'd0, 8'd0);
    send(CMD_SAMPLE, 4'd0, 8'd99);
    send(CMD_TICK, 4'd0, 8'd0);
    send(CMD_KEY, KEY_START_STOP, 8'd0);
    send(CMD_KEY, 4'd0, 8'd0);
    send(CMD_KEY, 4'd0, 8'd0);
    send(CMD_SAMPLE, 4'd0, 8'd0);
    send(CMD_KEY, KEY_START_STOP, 8'd0);
    send(CMD_SAMPLE, 4'd0, 8'd10);
    send(CMD_KEY, KEY_START_STOP, 8'd0);

    // every timeout stays above the total tick count until the last phase
    drain();
    set_config(0, 0, 65535);
    run_phase(90);
    hold_ask = 1'b1;
    run_phase(90);

    drain();
    set_config(255, 255, 1800);
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(180);
    gaps_on  = 1'b1;
    stall_on = 1'b1;

    drain();
    set_config($urandom_range(1, 20), $urandom_range(0, 60), $urandom_range(1800, 65535));
    run_phase(90);
    drain();
    run_phase(90);

    drain();
    set_config($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1800, 65535));
    run_phase(180);

    drain();
    set_config($urandom_range(2, 12), 255, 4000);
    run_phase(180);

    // last phase may overshoot or time out; error then latches for the rest
    drain();
    set_config($urandom_range(0, 10), $urandom_range(0, 40),
               ($urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 25));
    repeat (3) run_session(1'b0);
    repeat (30) send(cmd_t'($urandom_range(0, 3)), 4'($urandom), 8'($urandom));

    drain();
    repeat (5) @(posedge clk);
    $display("%0d requests (%0d with effect), %0d results compared, %0d register settings",
             sent, counted, checked, reg_sets);
    $display("covered digit entry, band and overshoot edges, stop priority, long stall, drains");
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hsup_pkg.sv
rtl/hsup_if.sv
rtl/hsup_cfg.sv
rtl/hsup_eval.sv
rtl/heater_supervisor_fsm.sv
test/heater_supervisor_check.sv
test/heater_supervisor_fsm_test.sv
